// ===== rtl/assert_macros.svh =====
// Assertion helpers for the register ALU checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication in the same cycle
`define RABU_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// implication in the next cycle
`define RABU_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== rtl/rabu_pkg.sv =====
`default_nettype none
package rabu_pkg;
    localparam int unsigned DataW = 32;

    typedef enum logic [4:0] {
        OP_LOAD  = 5'd0,
        OP_MOV   = 5'd1,
        OP_ADD   = 5'd2,
        OP_SUB   = 5'd3,
        OP_MUL   = 5'd4,
        OP_MOD   = 5'd5,
        OP_DIV   = 5'd6,
        OP_INC   = 5'd7,
        OP_DEC   = 5'd8,
        OP_EQ    = 5'd9,
        OP_GE    = 5'd10,
        OP_LE    = 5'd11,
        OP_GOTO  = 5'd12,
        OP_JZ    = 5'd13,
        OP_JNZ   = 5'd14,
        OP_SHIFT = 5'd15,
        OP_NOP   = 5'd16
    } op_t;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_DIVZERO = 2'd1;
    localparam logic [1:0] ST_BADREG = 2'd2;

    // command to the serial arithmetic unit
    typedef struct packed {
        logic start;
        logic is_mul;
    } seq_cmd_t;

    typedef struct packed {
        logic done;
    } seq_sts_t;
endpackage
`default_nettype wire

// ===== rtl/register_alu_branch_unit_top.sv =====
`default_nettype none
// Register ALU / branch unit.
// Input channel s_valid/s_ready carries one instruction word (s_mode, s_first_reg,
// s_second_reg, s_immediate). Output channel m_valid/m_ready carries one result
// word (m_status, m_instr_pointer, m_accumulator, m_written_value) per instruction.
// Config channel cfg_valid/cfg_ready writes code_base; write it only while idle.
// One instruction at a time: simple operations raise m_valid from the S_EXEC state;
// mul, div and mod (nonzero divisor) run on a shared bit-serial unit, one bit per cycle,
// 32 steps plus load and sign fix-up, and raise m_valid after the fix-up in S_FIN.
// The next word is accepted in the cycle after the result is taken.
// A stalled receiver holds the result and blocks input.
// Reset clears the register file, the instruction pointer and code_base to zero.
module register_alu_branch_unit_top
    import rabu_pkg::*;
#(
    parameter int unsigned REG_COUNT = 5
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [31:0]        cfg_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [4:0]         s_mode,
    input  wire logic [2:0]         s_first_reg,
    input  wire logic [2:0]         s_second_reg,
    input  wire logic signed [31:0] s_immediate,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [1:0]              m_status,
    output logic [31:0]             m_instr_pointer,
    output logic signed [31:0]      m_accumulator,
    output logic signed [31:0]      m_written_value
);
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_WAIT = 4'b0100,
        S_FIN  = 4'b1000
    } state_t;

    state_t      state_reg, state_next;
    logic [31:0] rf_reg [REG_COUNT];
    logic [31:0] ip_reg;
    logic [31:0] base_reg;
    logic [4:0]  mode_reg;
    logic [2:0]  r1_reg, r2_reg;
    logic [31:0] imm_reg;
    logic        out_valid_reg;
    logic [1:0]  st_reg;
    logic [31:0] wv_reg;
    logic        neg_a_reg, neg_q_reg;

    seq_cmd_t    cmd;
    seq_sts_t    sts;
    logic [31:0] prod, quot, rem;

    logic        ok1, ok2, need1, need2, bad;
    logic [31:0] a, b, ma, mb, sh_res, left;
    logic        s_acc;
    logic [31:0] fin_val;

    assign ok1 = 32'(r1_reg) < REG_COUNT;
    assign ok2 = 32'(r2_reg) < REG_COUNT;
    assign need1 = (mode_reg <= OP_LE) || (mode_reg == OP_GOTO) || (mode_reg == OP_SHIFT);
    assign need2 = (mode_reg >= OP_MOV) && (mode_reg <= OP_LE)
                   && (mode_reg != OP_INC) && (mode_reg != OP_DEC);
    assign bad = (need1 && !ok1) || (need2 && !ok2);
    assign a = ok1 ? rf_reg[r1_reg[$clog2(REG_COUNT)-1:0]] : '0;
    assign b = ok2 ? rf_reg[r2_reg[$clog2(REG_COUNT)-1:0]] : '0;
    assign ma = a[31] ? -a : a;
    assign mb = b[31] ? -b : b;
    assign left = -imm_reg;

    always_comb begin
        if (!imm_reg[31] && imm_reg != '0)
            sh_res = (imm_reg >= 32) ? {32{a[31]}} : 32'($signed(a) >>> imm_reg[4:0]);
        else
            sh_res = (left >= 32) ? '0 : a << left[4:0];
    end

    assign s_acc     = s_valid && s_ready;
    assign s_ready   = (state_reg == S_IDLE) && !out_valid_reg;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_status  = st_reg;
    assign m_instr_pointer = ip_reg;
    assign m_accumulator   = rf_reg[0];
    assign m_written_value = wv_reg;

    logic serial_op;
    assign serial_op = !bad && ((mode_reg == OP_MUL) ||
                       (((mode_reg == OP_DIV) || (mode_reg == OP_MOD)) && b != '0));
    assign cmd.start  = (state_reg == S_EXEC) && serial_op;
    assign cmd.is_mul = mode_reg == OP_MUL;

    rabu_serial_unit u_ser (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd),
        .op_a(cmd.is_mul ? a : ma), .op_b(cmd.is_mul ? b : mb),
        .sts(sts), .prod(prod), .quot(quot), .rem(rem)
    );

    // apply the sign to the serial result once its final step has landed
    always_comb begin
        case (mode_reg)
            OP_MUL:  fin_val = prod;
            OP_DIV:  fin_val = neg_q_reg ? -quot : quot;
            default: fin_val = neg_a_reg ? -rem : rem;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (s_acc) state_next = S_EXEC;
            S_EXEC:  state_next = serial_op ? S_WAIT : S_IDLE;
            S_WAIT:  if (sts.done) state_next = S_FIN;
            S_FIN:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            ip_reg        <= '0;
            base_reg      <= '0;
            for (int i = 0; i < REG_COUNT; i++) rf_reg[i] <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) base_reg <= cfg_data;
            if (out_valid_reg && m_ready) out_valid_reg <= 1'b0;
            if (state_reg == S_EXEC) begin
                neg_a_reg <= a[31];
                neg_q_reg <= a[31] ^ b[31];
                if (!serial_op) out_valid_reg <= 1'b1;
                st_reg <= ST_OK;
                wv_reg <= '0;
                if (bad) begin
                    st_reg <= ST_BADREG;
                end else begin
                    case (mode_reg)
                        OP_LOAD: begin
                            wv_reg <= imm_reg;
                            rf_reg[r1_reg[$clog2(REG_COUNT)-1:0]] <= imm_reg;
                        end
                        OP_MOV: begin
                            wv_reg <= b;
                            rf_reg[r1_reg[$clog2(REG_COUNT)-1:0]] <= b;
                        end
                        OP_ADD: begin wv_reg <= a + b; rf_reg[0] <= a + b; end
                        OP_SUB: begin wv_reg <= a - b; rf_reg[0] <= a - b; end
                        OP_MOD, OP_DIV: if (b == '0) st_reg <= ST_DIVZERO;
                        OP_INC: begin
                            wv_reg <= a + 1;
                            rf_reg[r1_reg[$clog2(REG_COUNT)-1:0]] <= a + 1;
                        end
                        OP_DEC: begin
                            wv_reg <= a - 1;
                            rf_reg[r1_reg[$clog2(REG_COUNT)-1:0]] <= a - 1;
                        end
                        OP_EQ: begin
                            wv_reg <= 32'(a == b); rf_reg[0] <= 32'(a == b);
                        end
                        OP_GE: begin
                            wv_reg <= 32'($signed(a) >= $signed(b));
                            rf_reg[0] <= 32'($signed(a) >= $signed(b));
                        end
                        OP_LE: begin
                            wv_reg <= 32'($signed(a) <= $signed(b));
                            rf_reg[0] <= 32'($signed(a) <= $signed(b));
                        end
                        OP_GOTO: ip_reg <= base_reg + a;
                        OP_JZ:   if (rf_reg[0] == '0) ip_reg <= base_reg + imm_reg;
                        OP_JNZ:  if (rf_reg[0] != '0) ip_reg <= base_reg + imm_reg;
                        OP_SHIFT: begin
                            wv_reg <= sh_res;
                            rf_reg[r1_reg[$clog2(REG_COUNT)-1:0]] <= sh_res;
                        end
                        default: ;
                    endcase
                end
            end
            if (state_reg == S_FIN) begin
                out_valid_reg <= 1'b1;
                wv_reg        <= fin_val;
                rf_reg[0]     <= fin_val;
            end
        end
        if (s_acc) begin
            mode_reg <= s_mode;
            r1_reg   <= s_first_reg;
            r2_reg   <= s_second_reg;
            imm_reg  <= s_immediate;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/rabu_serial_unit.sv =====
`default_nettype none
// Bit-serial multiply (shift-add) and restoring divide, 32 steps; the divide takes unsigned magnitudes.
module rabu_serial_unit
    import rabu_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire seq_cmd_t         cmd,
    input  wire logic [DataW-1:0] op_a,
    input  wire logic [DataW-1:0] op_b,
    output seq_sts_t              sts,
    output logic [DataW-1:0]      prod,
    output logic [DataW-1:0]      quot,
    output logic [DataW-1:0]      rem
);
    localparam int unsigned CntW = $clog2(DataW + 1);

    logic            busy_reg, busy_next;
    logic            mul_reg, mul_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic [DataW-1:0] acc_reg, acc_next;    // product or remainder
    logic [DataW-1:0] sh_reg, sh_next;      // multiplier / dividend shifting out
    logic [DataW-1:0] b_reg, b_next;        // multiplicand shifting / divisor held
    logic [DataW:0]   trial;

    always_comb begin
        busy_next = busy_reg;
        mul_next  = mul_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        sh_next   = sh_reg;
        b_next    = b_reg;
        trial     = {acc_reg, sh_reg[DataW-1]} - {1'b0, b_reg};
        if (cmd.start) begin
            busy_next = 1'b1;
            mul_next  = cmd.is_mul;
            cnt_next  = CntW'(DataW);
            acc_next  = '0;
            b_next    = cmd.is_mul ? op_a : op_b;
            sh_next   = cmd.is_mul ? op_b : op_a;
        end else if (busy_reg) begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_next == '0) busy_next = 1'b0;
            if (mul_reg) begin
                if (sh_reg[0]) acc_next = acc_reg + b_reg;
                sh_next = sh_reg >> 1;
                b_next  = b_reg << 1;
            end else begin
                if (!trial[DataW]) begin
                    acc_next = trial[DataW-1:0];
                    sh_next  = {sh_reg[DataW-2:0], 1'b1};
                end else begin
                    acc_next = {acc_reg[DataW-2:0], sh_reg[DataW-1]};
                    sh_next  = {sh_reg[DataW-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        mul_reg <= mul_next;
        acc_reg <= acc_next;
        sh_reg  <= sh_next;
        b_reg   <= b_next;
    end

    assign sts.done = busy_reg && (cnt_reg == CntW'(1));
    assign prod = acc_reg;
    assign quot = sh_reg;
    assign rem  = acc_reg;
endmodule
`default_nettype wire

// ===== rtl/rabu_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module rabu_sva_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [1:0]  m_status,
    input wire logic signed [31:0] m_written_value
);
    `RABU_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid)
    `RABU_ASSERT_IMP(a_no_accept_busy, aclk, aresetn, m_valid, !s_ready)
    `RABU_ASSERT_IMP(a_status_range, aclk, aresetn, m_valid, m_status != 2'd3)
    `RABU_ASSERT_IMP(a_err_no_write, aclk, aresetn, m_valid && m_status != 2'd0,
        m_written_value == 0)
endmodule

bind register_alu_branch_unit_top rabu_sva_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
    .m_written_value(m_written_value)
);
`default_nettype wire
